// File: rtl/ole_pkg.sv
`timescale 1ns / 1ps

package ole_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_FIND   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_REM  = 2'd2;

  typedef struct packed {
    logic [1:0]               op;
    logic [IDX_W-1:0]         at;
    logic [IDX_W-1:0]         rd_idx;
    logic [CNT_W-1:0]         len;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// File: rtl/ole_cell.sv
`timescale 1ns / 1ps

module ole_cell import ole_pkg::*; (
  input  logic                     clk,
  input  logic [IDX_W-1:0]         cell_idx,
  input  cell_ctrl_t               ctrl,
  input  logic signed [DATA_W-1:0] left_entry,
  input  logic signed [DATA_W-1:0] right_entry,
  output logic signed [DATA_W-1:0] entry,
  output logic signed [DATA_W-1:0] tap,
  output logic                     match
);

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;
  logic                     occupied;

  assign occupied = CNT_W'(cell_idx) < ctrl.len;
  assign match    = occupied && (entry_r == ctrl.value);
  assign tap      = (cell_idx == ctrl.rd_idx) ? entry_r : '0;
  assign entry    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      OP_INS: begin
        if (cell_idx == ctrl.at) begin
          entry_nxt = ctrl.value;
        end else if (cell_idx > ctrl.at) begin
          entry_nxt = left_entry;
        end
      end
      OP_REM: begin
        // close the gap: everything from the removed slot up moves down
        if (cell_idx >= ctrl.at) begin
          entry_nxt = right_entry;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// File: rtl/ole_chain.sv
`timescale 1ns / 1ps

module ole_chain import ole_pkg::*; (
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  output logic signed [DATA_W-1:0] rd_data,
  output logic [CAPACITY-1:0]      match_vec
);

  logic signed [DATA_W-1:0] ent  [CAPACITY];
  logic signed [DATA_W-1:0] taps [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_w;
    logic signed [DATA_W-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = ent[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = ent[g+1];
    end

    ole_cell u_cell (
      .clk         (clk),
      .cell_idx    (IDX_W'(g)),
      .ctrl        (ctrl),
      .left_entry  (left_w),
      .right_entry (right_w),
      .entry       (ent[g]),
      .tap         (taps[g]),
      .match       (match_vec[g])
    );
  end

  // only the selected cell drives a nonzero tap
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | taps[i];
    end
  end

endmodule

// File: rtl/ordered_list_engine_unit.sv
`timescale 1ns / 1ps

// Ordered list engine: a bounded list of signed 32-bit values held one per
// cell in a row of cells that shift toward or away from a position.
//
// Input channel (in_valid/in_ready): one command per item: in_cmd, in_position,
// in_value. Result channel (out_valid/out_ready): one result per item with
// out_result_value, out_found_position, out_found, out_status, out_count.
//
// An accepted item is executed in the cell row in the cycle after acceptance
// (shift, read tap and per-cell compare all at once); the S_FIN step then
// priority-encodes the match flags and loads the output register once it is
// free. A new item is accepted in the same cycle a result is loaded, so the
// block takes no new item while the previous one is still in execute or encode.
//
// Reset (rst_n low, synchronous) empties the list at once and drops any
// pending result; cell contents are not cleared. If the receiver stalls, the
// finished result holds in the output register and the next item waits in the
// encode step until the register frees up.

module ordered_list_engine_unit import ole_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_cmd,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic signed [6:0]        out_found_position,
  output logic                     out_found,
  output logic [1:0]               out_status,
  output logic [6:0]               out_count
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam int PW = CNT_W + POS_W;
  localparam logic signed [6:0] NONE_POS = 7'sh7F;

  logic [1:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [1:0]               cmd_r;
  logic [POS_W-1:0]         pos_r;
  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] res_r, res_nxt;
  logic [1:0]               st_r, st_nxt;
  logic [CAPACITY-1:0]      match_r;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_res_r;
  logic signed [6:0]        out_fpos_r;
  logic                     out_fnd_r;
  logic [1:0]               out_st_r;
  logic [6:0]               out_cnt_r;

  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] rd_data;
  logic [CAPACITY-1:0]      match_vec;

  logic [PW-1:0]            pos_x, len_x;
  logic [CNT_W-1:0]         pos_c, last_c, at_c;
  logic                     out_free, accept, load_out;
  logic                     hit;
  logic [IDX_W-1:0]         hit_idx;

  assign out_free = !out_valid_r || out_ready;
  assign load_out = (state_r == S_FIN) && out_free;
  assign in_ready = (state_r == S_IDLE) || load_out;
  assign accept   = in_valid && in_ready;

  assign pos_x  = {{CNT_W{1'b0}}, pos_r};
  assign len_x  = {{POS_W{1'b0}}, cnt_r};
  assign pos_c  = pos_x[CNT_W-1:0];
  assign last_c = cnt_r - 1'b1;

  // execute step: decide the cell operation, status, result and new length from the length
  always_comb begin
    ctrl.op     = OP_HOLD;
    ctrl.len    = cnt_r;
    ctrl.value  = val_r;
    at_c        = pos_c;
    res_nxt     = '0;
    st_nxt      = ST_OK;
    cnt_nxt     = cnt_r;
    unique case (cmd_r)
      CMD_INSERT: begin
        if (pos_x > len_x) begin
          at_c = cnt_r;
        end
        if (cnt_r == CNT_W'(CAPACITY)) begin
          st_nxt = ST_FULL;
        end else begin
          ctrl.op = OP_INS;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (pos_x >= len_x - 1'b1) begin
          at_c = last_c;
        end
        if (cnt_r == '0) begin
          st_nxt = ST_EMPTY;
        end else begin
          ctrl.op = OP_REM;
          res_nxt = rd_data;
          cnt_nxt = last_c;
        end
      end
      CMD_READ: begin
        if (pos_x >= len_x) begin
          res_nxt = '1;
          st_nxt  = ST_RANGE;
        end else begin
          res_nxt = rd_data;
        end
      end
      default: begin
        res_nxt = '0;
      end
    endcase
    if (state_r != S_EXEC) begin
      ctrl.op = OP_HOLD;
    end
    ctrl.at     = at_c[IDX_W-1:0];
    ctrl.rd_idx = at_c[IDX_W-1:0];
  end

  ole_chain u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .rd_data   (rd_data),
    .match_vec (match_vec)
  );

  // lowest matching cell wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: state_nxt = S_FIN;
      S_FIN: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end else if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EXEC) begin
        cnt_r <= cnt_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (state_r == S_EXEC) begin
      res_r   <= res_nxt;
      st_r    <= st_nxt;
      match_r <= match_vec;
    end
    if (load_out) begin
      out_res_r <= res_r;
      out_st_r  <= st_r;
      out_cnt_r <= 7'(cnt_r);
      if ((cmd_r == CMD_FIND) && hit) begin
        out_fpos_r <= 7'(hit_idx);
        out_fnd_r  <= 1'b1;
      end else begin
        out_fpos_r <= NONE_POS;
        out_fnd_r  <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_value   = out_res_r;
  assign out_found_position = out_fpos_r;
  assign out_found          = out_fnd_r;
  assign out_status         = out_st_r;
  assign out_count          = out_cnt_r;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ole_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic signed [6:0] NO_MATCH = -7'sd1;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [6:0]        fpos;
    logic                     found;
    logic [1:0]               status;
    logic [6:0]               count;
  } list_outcome_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               in_cmd;
  logic [POS_W-1:0]         in_position;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] out_result_value;
  logic signed [6:0]        out_found_position;
  logic                     out_found;
  logic [1:0]               out_status;
  logic [6:0]               out_count;

  // shadow copy of the list
  logic signed [DATA_W-1:0] list_vals [0:CAPACITY-1];
  int                       list_len;

  list_outcome_t outcome_q[$];
  list_outcome_t got_outcome;
  list_outcome_t want_outcome;
  int            mismatch_count;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            hold_cycles;
  int            quiet_cycles;

  ordered_list_engine_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_value  (out_result_value),
    .out_found_position(out_found_position),
    .out_found         (out_found),
    .out_status        (out_status),
    .out_count         (out_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic list_outcome_t apply_list_cmd(logic [1:0] cmd, logic [POS_W-1:0] pos,
                                                   logic signed [DATA_W-1:0] val);
    list_outcome_t o;
    int            p;
    int            at;
    int            i;
    p = pos;
    o.value = '0;
    o.fpos = NO_MATCH;
    o.found = 1'b0;
    o.status = ST_OK;
    case (cmd)
      CMD_INSERT: begin
        if (list_len >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          at = (p > list_len) ? list_len : p;
          for (i = list_len; i > at; i--) list_vals[i] = list_vals[i-1];
          list_vals[at] = val;
          list_len++;
        end
      end
      CMD_REMOVE: begin
        if (list_len == 0) begin
          o.status = ST_EMPTY;
        end else begin
          at = (p >= list_len - 1) ? list_len - 1 : p;
          o.value = list_vals[at];
          for (i = at; i < list_len - 1; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      CMD_READ: begin
        if (p >= list_len) begin
          o.value = -1;
          o.status = ST_RANGE;
        end else begin
          o.value = list_vals[p];
        end
      end
      default: begin
        for (i = 0; i < list_len; i++) begin
          if (!o.found && list_vals[i] == val) begin
            o.fpos = 7'(i);
            o.found = 1'b1;
          end
        end
      end
    endcase
    o.count = list_len[6:0];
    return o;
  endfunction

  // call at a falling edge; returns at a falling edge with valid still high
  task automatic send_item(logic [1:0] cmd, logic [POS_W-1:0] pos,
                           logic signed [DATA_W-1:0] val);
    list_outcome_t o;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_cmd = cmd;
    in_position = pos;
    in_value = val;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    o = apply_list_cmd(cmd, pos, val);
    outcome_q.push_back(o);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  // receiver: random stalls, or a counted hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready = 1'b0;
      hold_cycles--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_outcome.value = out_result_value;
      got_outcome.fpos = out_found_position;
      got_outcome.found = out_found;
      got_outcome.status = out_status;
      got_outcome.count = out_count;
      if (outcome_q.size() == 0) begin
        $display("%0t: result with no command pending: %h", $time, got_outcome);
        mismatch_count++;
      end else begin
        want_outcome = outcome_q.pop_front();
        check_field("result_value", want_outcome.value, got_outcome.value);
        check_field("found_position", 32'(want_outcome.fpos), 32'(got_outcome.fpos));
        check_field("found", 32'(want_outcome.found), 32'(got_outcome.found));
        check_field("status", 32'(want_outcome.status), 32'(got_outcome.status));
        check_field("count", 32'(want_outcome.count), 32'(got_outcome.count));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("ordered_list_engine_unit test failed");
        $finish;
      end
    end
  end

  task automatic test_basic_ops();
    send_item(CMD_REMOVE, 0, 0);              // remove on empty list
    send_item(CMD_READ, 0, 0);                // read on empty list
    send_item(CMD_FIND, 0, 0);                // find on empty list
    send_item(CMD_INSERT, 63, 32'sh7FFF_FFFF); // position past end appends
    send_item(CMD_INSERT, 0, 32'sh8000_0000);  // insert at front
    send_item(CMD_INSERT, 1, 0);              // insert in the middle
    send_item(CMD_INSERT, 63, -1);
    send_item(CMD_INSERT, 2, 32'sh5555_AAAA);
    send_item(CMD_READ, 0, 0);
    send_item(CMD_READ, 4, 0);
    send_item(CMD_READ, 5, 0);                // read just past end
    send_item(CMD_READ, 63, 0);
    send_item(CMD_FIND, 0, 32'sh7FFF_FFFF);
    send_item(CMD_FIND, 63, 32'sh8000_0000);
    send_item(CMD_FIND, 0, 12345);            // no match
    send_item(CMD_INSERT, 3, 0);              // duplicate, find must report first
    send_item(CMD_FIND, 0, 0);
    send_item(CMD_REMOVE, 1, 0);              // middle remove
    send_item(CMD_REMOVE, 63, 0);             // clamps to last entry
    send_item(CMD_REMOVE, 3, 0);              // exactly the last entry
    send_item(CMD_REMOVE, 0, 0);
    wait_drained();
  endtask

  task automatic test_full_list();
    while (list_len < CAPACITY)
      send_item(CMD_INSERT, POS_W'($urandom_range(63)), $urandom);
    send_item(CMD_INSERT, 0, 7);              // rejected, list full
    send_item(CMD_INSERT, 63, -7);
    send_item(CMD_READ, 63, 0);
    send_item(CMD_FIND, 0, list_vals[CAPACITY-1]);
    send_item(CMD_REMOVE, 63, 0);
    send_item(CMD_INSERT, 63, 32'sh0F0F_F0F0);
    wait_drained();
  endtask

  task automatic run_random_phase(int n_items, int idle_pct, int stall_pct);
    logic [1:0]               cmd;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    int                       fill_target;
    int                       r;
    int                       n;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    fill_target = $urandom_range(CAPACITY);
    for (n = 0; n < n_items; n++) begin
      if (n % 40 == 0)
        fill_target = ($urandom_range(3) == 0) ? ($urandom_range(1) ? CAPACITY : 0)
                                                : $urandom_range(CAPACITY);
      r = $urandom_range(99);
      if (r < 45) begin
        // steer the length toward the target so full and empty get reached
        if (list_len < fill_target) cmd = CMD_INSERT;
        else if (list_len > fill_target) cmd = CMD_REMOVE;
        else cmd = $urandom_range(1) ? CMD_INSERT : CMD_REMOVE;
      end else begin
        cmd = 2'($urandom_range(3));
      end
      case ($urandom_range(3))
        0: pos = POS_W'($urandom_range(63));
        1: pos = POS_W'((list_len == 0) ? 0 : ((list_len - 1 > 63) ? 63 : list_len - 1));
        2: pos = POS_W'((list_len > 63) ? 63 : list_len);
        default: pos = POS_W'((list_len == 0) ? 0 : $urandom_range(list_len - 1));
      endcase
      case ($urandom_range(9))
        0, 1, 2: val = $signed($urandom_range(4)) - 2;
        3: val = $urandom_range(1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        default: val = $urandom;
      endcase
      if (cmd == CMD_FIND && list_len > 0 && $urandom_range(99) < 60)
        val = list_vals[$urandom_range(list_len - 1)];
      send_item(cmd, pos, val);
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    run_random_phase(400, 0, 0);
    run_random_phase(400, 72, 0);
    run_random_phase(400, 0, 72);
    run_random_phase(400, 10, 10);
  endtask

  task automatic test_backpressure();
    int n;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_cycles = HOLD_OFF_CYCLES;
    @(negedge clk);
    // keep offering items while the output is held off
    for (n = 0; n < 12; n++)
      send_item(n % 3 == 0 ? CMD_FIND : CMD_INSERT, POS_W'($urandom_range(63)), $urandom);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_INSERT;
    in_position = '0;
    in_value = '0;
    out_ready = 1'b0;
    list_len = 0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_basic_ops();
    test_full_list();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ordered_list_engine_unit test passed");
    end else begin
      $display("ordered_list_engine_unit test failed");
    end
    $finish;
  end

endmodule
